// ===== hw/rtl/ipmf_pkg.sv =====
// Shared types, constants and helper functions for the IPv4 mask filter table.
// No dependencies; every other file in hw/rtl refers to it by scoped names.
package ipmf_pkg;

    // Table geometry
    localparam int MAX_ENTRIES = 1024;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = 11;

    // Stream payload widths
    localparam int ADDR_W      = 32;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int OUT_W       = 16;

    // Marker of a free slot, and the all-ones octet
    localparam logic [ADDR_W-1:0] FREE_MARK  = 32'hffff_ffff;
    localparam logic [7:0]        OCTET_FULL = 8'hff;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;

    // Item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_CHECK  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_SHIFT = 2'd2,
        ST_RESP  = 2'd3
    } state_t;

    // Request from the sequencer to the filter memory
    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [ADDR_W-1:0] wr_data;
    } ram_req_t;

    // One mask bit per nonzero octet
    function automatic logic [3:0] octet_mask_of(input logic [ADDR_W-1:0] v);
        logic [3:0] m;
        m = '0;
        for (int i = 0; i < 4; i++) begin
            m[i] = (v[8*i +: 8] != 8'd0);
        end
        return m;
    endfunction

    // Widen a mask bit to cover its whole octet
    function automatic logic [ADDR_W-1:0] expand_mask(input logic [3:0] m);
        logic [ADDR_W-1:0] e;
        e = '0;
        for (int i = 0; i < 4; i++) begin
            e[8*i +: 8] = m[i] ? OCTET_FULL : 8'd0;
        end
        return e;
    endfunction

endpackage

// ===== hw/rtl/ipmf_ram.sv =====
// Filter memory: one write port and one read port with registered read data.
// Depends on ipmf_pkg for the table depth and the request struct.
module ipmf_ram (
    input  logic                       clk,
    input  ipmf_pkg::ram_req_t         req,
    output logic [ipmf_pkg::ADDR_W-1:0] rd_data
);

    logic [ipmf_pkg::ADDR_W-1:0] mem [ipmf_pkg::MAX_ENTRIES];

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// ===== hw/rtl/ipmf_match.sv =====
// Shared compare unit: tests one stored filter against the current item.
// Depends on ipmf_pkg for the kind codes and the mask helpers.
module ipmf_match (
    input  ipmf_pkg::kind_t             kind,
    input  logic [ipmf_pkg::ADDR_W-1:0] addr,
    input  logic [ipmf_pkg::ADDR_W-1:0] cmp,
    input  logic [ipmf_pkg::ADDR_W-1:0] entry,
    output logic                        hit
);

    logic [ipmf_pkg::ADDR_W-1:0] entry_mask;

    // Stored compare values carry their own mask: one bit per nonzero octet
    assign entry_mask = ipmf_pkg::expand_mask(ipmf_pkg::octet_mask_of(entry));

    // Select the test for this kind of item
    always_comb
    begin
        case (kind)
            ipmf_pkg::KIND_ADD:    hit = (entry == ipmf_pkg::FREE_MARK);
            ipmf_pkg::KIND_REMOVE: hit = (entry == cmp);
            ipmf_pkg::KIND_CHECK:  hit = ((addr & entry_mask) == entry);
            default:               hit = 1'b0;
        endcase
    end

endmodule

// ===== hw/rtl/ipmf_ctrl.sv =====
// Sequencer: scans the filter memory one entry per cycle, shifts on remove,
// and holds the result register. Depends on ipmf_pkg and drives ipmf_ram.
module ipmf_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          ban_mode,
    // item input
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ipmf_pkg::ADDR_W-1:0]   s_axis_tdata,
    input  logic [ipmf_pkg::KIND_W-1:0]   s_axis_tuser,
    // result output
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ipmf_pkg::OUT_W-1:0]    m_axis_tdata,
    // memory and compare unit
    output ipmf_pkg::ram_req_t            ram_req,
    input  logic [ipmf_pkg::ADDR_W-1:0]   rd_data,
    output ipmf_pkg::kind_t               match_kind,
    output logic [ipmf_pkg::ADDR_W-1:0]  match_addr,
    output logic [ipmf_pkg::ADDR_W-1:0]  match_cmp,
    input  logic                          match_hit
);

    localparam logic [ipmf_pkg::CNT_W-1:0] CNT_MAX = ipmf_pkg::CNT_W'(ipmf_pkg::MAX_ENTRIES);
    localparam logic [ipmf_pkg::CNT_W-1:0] CNT_ONE = ipmf_pkg::CNT_W'(1);
    localparam logic [ipmf_pkg::IDX_W-1:0] IDX_ONE = ipmf_pkg::IDX_W'(1);

    ipmf_pkg::state_t                 state_reg, state_next;
    ipmf_pkg::kind_t                  kind_reg, kind_next;
    logic [ipmf_pkg::ADDR_W-1:0]      addr_reg, addr_next;
    logic [ipmf_pkg::ADDR_W-1:0]      cmp_reg, cmp_next;
    logic [ipmf_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [ipmf_pkg::CNT_W-1:0]       issue_reg, issue_next;
    logic                             rd_vld_reg, rd_vld_next;
    logic [ipmf_pkg::IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                             res_blocked_reg, res_blocked_next;
    logic [ipmf_pkg::STATUS_W-1:0]    res_status_reg, res_status_next;
    logic                             out_valid_reg, out_valid_next;
    logic [ipmf_pkg::OUT_W-1:0]       out_data_reg, out_data_next;

    logic in_accept;
    logic scan_hit;
    logic scan_end;
    logic shift_end;
    logic can_issue;
    logic out_free;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign scan_hit  = rd_vld_reg && match_hit;
    assign can_issue = (issue_reg < count_reg);
    assign scan_end  = scan_hit || (!rd_vld_reg && !can_issue);
    assign shift_end = !rd_vld_reg && !can_issue;
    assign out_free  = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == ipmf_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign match_kind = kind_reg;
    assign match_addr = addr_reg;
    assign match_cmp  = cmp_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ipmf_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (ipmf_pkg::kind_t'(s_axis_tuser) == ipmf_pkg::KIND_NONE)
                        ? ipmf_pkg::ST_RESP : ipmf_pkg::ST_SCAN;
                end
            end
            ipmf_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = (kind_reg == ipmf_pkg::KIND_REMOVE && scan_hit)
                        ? ipmf_pkg::ST_SHIFT : ipmf_pkg::ST_RESP;
                end
            end
            ipmf_pkg::ST_SHIFT:
            begin
                if (shift_end)
                begin
                    state_next = ipmf_pkg::ST_RESP;
                end
            end
            ipmf_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ipmf_pkg::ST_IDLE;
                end
            end
            default: state_next = ipmf_pkg::ST_IDLE;
        endcase
    end

    // Datapath, memory requests and result register
    always_comb
    begin
        kind_next        = kind_reg;
        addr_next        = addr_reg;
        cmp_next         = cmp_reg;
        count_next       = count_reg;
        issue_next       = issue_reg;
        rd_vld_next      = 1'b0;
        rd_idx_next      = rd_idx_reg;
        res_blocked_next = res_blocked_reg;
        res_status_next  = res_status_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_data_next    = out_data_reg;
        ram_req          = '0;

        unique case (state_reg)
            ipmf_pkg::ST_IDLE:
            begin
                // Capture the item and derive its masked compare value
                if (in_accept)
                begin
                    kind_next        = ipmf_pkg::kind_t'(s_axis_tuser);
                    addr_next        = s_axis_tdata;
                    cmp_next         = s_axis_tdata & ipmf_pkg::expand_mask(
                                           ipmf_pkg::octet_mask_of(s_axis_tdata));
                    issue_next       = '0;
                    res_blocked_next = 1'b0;
                    res_status_next  = ipmf_pkg::STAT_DONE;
                end
            end
            ipmf_pkg::ST_SCAN:
            begin
                // Issue the next read until a hit comes back or no entry is left to read
                if (!scan_hit && can_issue)
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = issue_reg[ipmf_pkg::IDX_W-1:0];
                    rd_vld_next     = 1'b1;
                    rd_idx_next     = issue_reg[ipmf_pkg::IDX_W-1:0];
                    issue_next      = issue_reg + CNT_ONE;
                end
                if (scan_end)
                begin
                    case (kind_reg)
                        ipmf_pkg::KIND_ADD:
                        begin
                            if (scan_hit)
                            begin
                                ram_req.wr_en   = 1'b1;
                                ram_req.wr_addr = rd_idx_reg;
                                ram_req.wr_data = cmp_reg;
                            end
                            else if (count_reg == CNT_MAX)
                            begin
                                res_status_next = ipmf_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ram_req.wr_en   = 1'b1;
                                ram_req.wr_addr = count_reg[ipmf_pkg::IDX_W-1:0];
                                ram_req.wr_data = cmp_reg;
                                count_next      = count_reg + CNT_ONE;
                            end
                        end
                        ipmf_pkg::KIND_REMOVE:
                        begin
                            if (scan_hit)
                            begin
                                issue_next = {1'b0, rd_idx_reg} + CNT_ONE;
                            end
                            else
                            begin
                                res_status_next = ipmf_pkg::STAT_NOT_FOUND;
                            end
                        end
                        ipmf_pkg::KIND_CHECK:
                        begin
                            res_blocked_next = scan_hit ? ban_mode : !ban_mode;
                        end
                        default: res_blocked_next = 1'b0;
                    endcase
                end
            end
            ipmf_pkg::ST_SHIFT:
            begin
                // Move each later entry down by one slot
                if (rd_vld_reg)
                begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = rd_idx_reg - IDX_ONE;
                    ram_req.wr_data = rd_data;
                end
                if (can_issue)
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = issue_reg[ipmf_pkg::IDX_W-1:0];
                    rd_vld_next     = 1'b1;
                    rd_idx_next     = issue_reg[ipmf_pkg::IDX_W-1:0];
                    issue_next      = issue_reg + CNT_ONE;
                end
                if (shift_end)
                begin
                    count_next = count_reg - CNT_ONE;
                end
            end
            ipmf_pkg::ST_RESP:
            begin
                // Load the result once the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{(ipmf_pkg::OUT_W - ipmf_pkg::CNT_W
                                        - ipmf_pkg::STATUS_W - 1){1'b0}},
                                      count_reg, res_status_reg, res_blocked_reg};
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ipmf_pkg::ST_IDLE;
            count_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        addr_reg        <= addr_next;
        cmp_reg         <= cmp_next;
        issue_reg       <= issue_next;
        rd_idx_reg      <= rd_idx_next;
        res_blocked_reg <= res_blocked_next;
        res_status_reg  <= res_status_next;
        out_data_reg    <= out_data_next;
    end

    // The count never passes the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
    else $error("filter count above table size");

    // Reads stay below the count
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.rd_en |-> ({1'b0, ram_req.rd_addr} < count_reg))
    else $error("read at or above filter count");

    // Writes stay below the count, or append at it
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.wr_en |-> ({1'b0, ram_req.wr_addr} <= count_reg))
    else $error("write beyond end of table");

    // The count moves only at the end of a scan or a shift
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ($past(state_reg) == ipmf_pkg::ST_SCAN || $past(state_reg) == ipmf_pkg::ST_SHIFT))
    else $error("filter count changed outside scan or shift");

endmodule

// ===== hw/rtl/ip_mask_filter_table.sv =====
// Top level of the IPv4 mask filter table: ban mode register and stream ports.
// Depends on ipmf_pkg and instantiates ipmf_ram, ipmf_match and ipmf_ctrl.

// An item (add, remove or check) is taken only while the block is idle. Once taken,
// each filter held is read in turn from the single read port of the filter
// memory and compared, the scan is closed after the last compare, and the
// result is loaded once the output register is free. An add or a check that
// hits stops the scan early. A remove that hits adds the shift of the later
// entries, which continues on from the hit. The table holds up to 1024
// filters; the result register lets the next item be taken while the last
// result waits downstream.
module ip_mask_filter_table (
    input  logic                         clk,
    input  logic                         rst_n,
    // ban mode write: bit 0 = ban_mode
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_data,
    // items in
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [ipmf_pkg::ADDR_W-1:0]  s_axis_tdata,  // [31:0] address
    input  logic [ipmf_pkg::KIND_W-1:0]  s_axis_tuser,  // [1:0] kind
    // results out
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [ipmf_pkg::OUT_W-1:0]   m_axis_tdata   // [0] blocked, [2:1] status,
                                                        // [13:3] entry_count, [15:14] zero
);

    logic                        ban_mode_reg, ban_mode_next;
    ipmf_pkg::ram_req_t          ram_req;
    logic [ipmf_pkg::ADDR_W-1:0] rd_data;
    ipmf_pkg::kind_t             match_kind;
    logic [ipmf_pkg::ADDR_W-1:0] match_addr;
    logic [ipmf_pkg::ADDR_W-1:0] match_cmp;
    logic                        match_hit;

    // Take the ban mode write in any cycle
    assign cfg_ready     = 1'b1;
    assign ban_mode_next = (cfg_valid && cfg_ready) ? cfg_data : ban_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ban_mode_reg <= 1'b1;
        end
        else
        begin
            ban_mode_reg <= ban_mode_next;
        end
    end

    ipmf_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    ipmf_match u_match (
        .kind  (match_kind),
        .addr  (match_addr),
        .cmp   (match_cmp),
        .entry (rd_data),
        .hit   (match_hit)
    );

    ipmf_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .ban_mode      (ban_mode_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .ram_req       (ram_req),
        .rd_data       (rd_data),
        .match_kind    (match_kind),
        .match_addr    (match_addr),
        .match_cmp     (match_cmp),
        .match_hit     (match_hit)
    );

endmodule
